>>> rtl/xtea_pkg.sv
// XTEA shared types, constants and the round mixing function.
`default_nettype none

package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned KEY_SEL_W = 2;

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 32'h9E37_79B9;

  localparam int unsigned MIX_SHL = 4;
  localparam int unsigned MIX_SHR = 5;
  localparam int unsigned SUM_KEY_SHIFT = 11;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // one block in flight through the cell row
  typedef struct packed {
    action_t           action;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } stage_t;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
    return ((x << MIX_SHL) ^ (x >> MIX_SHR)) + x;
  endfunction

endpackage

`default_nettype wire

>>> rtl/xtea_block_cipher.sv
// XTEA block cipher top level: key registers and a row of half-round cells.
//
//  port group                       dir  notes
//  start / busy, action, block_in   in   one word accepted when start & !busy
//  done, block_out                  out  result word valid for the done cycle
//  wr_en, wr_index, wr_data         in   key word write, index 0..3
//
// A new word is accepted every cycle; busy is never raised.
// Each word passes one registered cell per Feistel half-round, so the cell
// row holds up to 2*CYCLE_COUNT words at once.
// Results come in input order; the receiver cannot stall.
// Synchronous reset clears the key and flushes every word in flight.
`default_nettype none

module xtea_block_cipher #(
  parameter int CYCLE_COUNT = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                action,
  input  wire logic [2*xtea_pkg::WORD_W-1:0]       block_in,
  output logic                                     done,
  output logic [2*xtea_pkg::WORD_W-1:0]            block_out,
  input  wire logic                                wr_en,
  input  wire logic [xtea_pkg::KEY_SEL_W-1:0]      wr_index,
  input  wire logic [xtea_pkg::WORD_W-1:0]         wr_data
);

  localparam int LATENCY = 2 * CYCLE_COUNT;

  xtea_pkg::key_t   key;
  logic             valid_chain [0:LATENCY];
  xtea_pkg::stage_t word_chain  [0:LATENCY];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      key[wr_index] <= wr_data;
    end
  end

  assign busy = 1'b0;

  assign valid_chain[0] = start;
  assign word_chain[0]  = {xtea_pkg::action_t'(action), block_in};

  for (genvar i = 0; i < LATENCY; i++) begin : g_cell
    xtea_cell #(
      .CYCLE_COUNT(CYCLE_COUNT),
      .CELL_INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .valid_in (valid_chain[i]),
      .word_in  (word_chain[i]),
      .valid_out(valid_chain[i+1]),
      .word_out (word_chain[i+1])
    );
  end

  assign done      = valid_chain[LATENCY];
  assign block_out = {word_chain[LATENCY].hi, word_chain[LATENCY].lo};

  // every result word traces back to an accepted word that entered the cell row
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result word without matching accepted word");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word lost in cell row");

  a_action_carried: assert property (@(posedge clk) disable iff (rst)
    done |-> (word_chain[LATENCY].action == xtea_pkg::action_t'($past(action, LATENCY))))
    else $error("action bit corrupted in cell row");

  a_key_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (key[$past(wr_index)] == $past(wr_data)))
    else $error("key word write not taken");

endmodule

`default_nettype wire

>>> rtl/xtea_cell.sv
// One XTEA half-round cell: a single registered Feistel half-round step.
`default_nettype none

module xtea_cell #(
  parameter int CYCLE_COUNT = 32,
  parameter int CELL_INDEX  = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire xtea_pkg::key_t   key,
  input  wire logic             valid_in,
  input  wire xtea_pkg::stage_t word_in,
  output logic                  valid_out,
  output xtea_pkg::stage_t      word_out
);

  localparam int ROUND    = CELL_INDEX / 2;
  localparam int PHASE    = CELL_INDEX % 2;
  localparam int ENC_MULT = ROUND + PHASE;
  localparam int DEC_MULT = CYCLE_COUNT - ROUND - PHASE;

  localparam logic [63:0] ENC_PROD = 64'(xtea_pkg::GOLDEN_STEP) * 64'(ENC_MULT);
  localparam logic [63:0] DEC_PROD = 64'(xtea_pkg::GOLDEN_STEP) * 64'(DEC_MULT);
  localparam logic [xtea_pkg::WORD_W-1:0] ENC_SUM = ENC_PROD[xtea_pkg::WORD_W-1:0];
  localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM = DEC_PROD[xtea_pkg::WORD_W-1:0];

  // first half of an encrypt cycle picks the key by sum[1:0], second by sum[12:11];
  // decryption runs the halves mirrored
  localparam logic [xtea_pkg::KEY_SEL_W-1:0] ENC_SEL = (PHASE == 0) ?
    ENC_SUM[xtea_pkg::KEY_SEL_W-1:0] :
    ENC_SUM[xtea_pkg::SUM_KEY_SHIFT +: xtea_pkg::KEY_SEL_W];
  localparam logic [xtea_pkg::KEY_SEL_W-1:0] DEC_SEL = (PHASE == 0) ?
    DEC_SUM[xtea_pkg::SUM_KEY_SHIFT +: xtea_pkg::KEY_SEL_W] :
    DEC_SUM[xtea_pkg::KEY_SEL_W-1:0];
  localparam logic HI_ON_ENC = (PHASE == 0);

  logic                         decrypt;
  logic                         upd_hi;
  logic [xtea_pkg::WORD_W-1:0]  src;
  logic [xtea_pkg::WORD_W-1:0]  dst;
  logic [xtea_pkg::WORD_W-1:0]  salt;
  logic [xtea_pkg::WORD_W-1:0]  f_val;
  logic [xtea_pkg::WORD_W-1:0]  res;
  xtea_pkg::stage_t             word_next;

  always_comb begin
    decrypt = (word_in.action == xtea_pkg::ACT_DECRYPT);
    upd_hi  = decrypt ? !HI_ON_ENC : HI_ON_ENC;
    src     = upd_hi ? word_in.lo : word_in.hi;
    dst     = upd_hi ? word_in.hi : word_in.lo;
    salt    = decrypt ? (DEC_SUM + key[DEC_SEL]) : (ENC_SUM + key[ENC_SEL]);
    f_val   = xtea_pkg::mix_word(src) ^ salt;
    res     = decrypt ? (dst - f_val) : (dst + f_val);
    word_next        = word_in;
    word_next.hi     = upd_hi ? res : word_in.hi;
    word_next.lo     = upd_hi ? word_in.lo : res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    word_out <= word_next;
  end

endmodule

`default_nettype wire

>>> test/xtea_block_cipher_test.sv
// Self-checking testbench for the XTEA block cipher pipeline.
`timescale 1ns / 100ps

module xtea_block_cipher_test;

  localparam int ROUNDS = 32;
  localparam int LATENCY = 2 * ROUNDS;
  localparam int STALL_LIMIT = 2000;
  localparam int DIRECTED_ROWS = 20;
  localparam int PHASES = 4;
  localparam int WORDS_PER_PHASE = 110;

  typedef enum logic {
    ROW_WORD,
    ROW_KEY
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    xtea_pkg::action_t  act;
    logic [63:0]        blk;
    logic [127:0]       key;
  } vector_row_t;

  vector_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'h0000_0000_0000_0000, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'h0000_0000_0000_0000, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0},
    '{ROW_KEY,  xtea_pkg::ACT_ENCRYPT, 64'h0, 128'h00010203_04050607_08090A0B_0C0D0E0F},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'h4142_4344_4546_4748, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'h497D_F3D0_7261_2CB5, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'h0000_0000_0000_0000, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'h8000_0000_0000_0001, 128'h0},
    '{ROW_KEY,  xtea_pkg::ACT_ENCRYPT, 64'h0, {128{1'b1}}},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'h0000_0000_0000_0000, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'h0000_0000_0000_0000, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0},
    '{ROW_KEY,  xtea_pkg::ACT_ENCRYPT, 64'h0, 128'h80000000_00000001_7FFFFFFF_FFFFFFFE},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'h5555_5555_5555_5555, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_ENCRYPT, 64'hFFFF_FFFF_0000_0000, 128'h0},
    '{ROW_WORD, xtea_pkg::ACT_DECRYPT, 64'h0000_0000_FFFF_FFFF, 128'h0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        action = 1'b0;
  logic [63:0] block_in = '0;
  logic        done;
  logic [63:0] block_out;
  logic        wr_en = 1'b0;
  logic [xtea_pkg::KEY_SEL_W-1:0] wr_index = '0;
  logic [xtea_pkg::WORD_W-1:0]    wr_data = '0;

  logic [xtea_pkg::WORD_W-1:0] key_shadow [xtea_pkg::KEY_WORDS];
  logic [63:0] pending_blocks [$];
  int unsigned mismatch_count = 0;
  int unsigned stall_count = 0;
  int unsigned encrypt_words = 0;
  int unsigned decrypt_words = 0;
  int unsigned key_loads = 0;
  logic [63:0] last_result = '0;
  xtea_pkg::action_t last_act = xtea_pkg::ACT_ENCRYPT;

  xtea_block_cipher #(
    .CYCLE_COUNT(ROUNDS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .block_in(block_in),
    .done(done),
    .block_out(block_out),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] round_mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic logic [63:0] xtea_transform(input xtea_pkg::action_t act,
                                                 input logic [63:0] blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] acc;
    hi = blk[63:32];
    lo = blk[31:0];
    if (act == xtea_pkg::ACT_DECRYPT) begin
      acc = xtea_pkg::GOLDEN_STEP * 32'(ROUNDS);
      for (int n = 0; n < ROUNDS; n++) begin
        lo = lo - (round_mix(hi) ^ (acc + key_shadow[acc[12:11]]));
        acc = acc - xtea_pkg::GOLDEN_STEP;
        hi = hi - (round_mix(lo) ^ (acc + key_shadow[acc[1:0]]));
      end
    end else begin
      acc = '0;
      for (int n = 0; n < ROUNDS; n++) begin
        hi = hi + (round_mix(lo) ^ (acc + key_shadow[acc[1:0]]));
        acc = acc + xtea_pkg::GOLDEN_STEP;
        lo = lo + (round_mix(hi) ^ (acc + key_shadow[acc[12:11]]));
      end
    end
    return {hi, lo};
  endfunction

  // start stays high on return so back-to-back words need no extra step
  task automatic send_word(input xtea_pkg::action_t act, input logic [63:0] blk);
    start <= 1'b1;
    action <= act;
    block_in <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    last_result = xtea_transform(act, blk);
    last_act = act;
    pending_blocks.push_back(last_result);
    if (act == xtea_pkg::ACT_DECRYPT) decrypt_words++;
    else encrypt_words++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    action <= 1'($urandom);
    block_in <= {$urandom(), $urandom()};
    repeat (n) @(posedge clk);
  endtask

  // key changes only with the pipeline empty
  task automatic load_key(input logic [127:0] k);
    start <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) begin
      wr_en <= 1'b1;
      wr_index <= i[xtea_pkg::KEY_SEL_W-1:0];
      wr_data <= k[127-32*i -: 32];
      @(posedge clk);
      key_shadow[i] = k[127-32*i -: 32];
    end
    wr_en <= 1'b0;
    key_loads++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_blocks.size() == 0) begin
        $error("block_out: result with no word pending, got %h", block_out);
        mismatch_count++;
      end else begin
        logic [63:0] want;
        want = pending_blocks.pop_front();
        if (block_out !== want) begin
          $error("block_out: expected %h, got %h", want, block_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $error("no word moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    int unsigned idle_pct [PHASES];
    int unsigned burst_left;
    xtea_pkg::action_t act;
    logic [63:0] blk;

    idle_pct = '{0, 66, 0, 11};
    burst_left = 0;
    for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) key_shadow[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_KEY) load_key(directed_rows[r].key);
      else send_word(directed_rows[r].act, directed_rows[r].blk);
    end

    for (int p = 0; p < PHASES; p++) begin
      load_key({$urandom(), $urandom(), $urandom(), $urandom()});
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        act = xtea_pkg::action_t'($urandom_range(1));
        case ($urandom_range(9))
          0: blk = '0;
          1: blk = '1;
          2: blk = 64'(1) << $urandom_range(63);
          // feed the last result back the other way for a round trip
          3: begin
            blk = last_result;
            act = (last_act == xtea_pkg::ACT_ENCRYPT) ? xtea_pkg::ACT_DECRYPT :
                                                        xtea_pkg::ACT_ENCRYPT;
          end
          default: blk = {$urandom(), $urandom()};
        endcase
        send_word(act, blk);
        if (burst_left != 0) begin
          burst_left--;
        end else if ($urandom_range(15) == 0) begin
          burst_left = $urandom_range(12, 4);
        end else if ($urandom_range(99) < idle_pct[p]) begin
          idle_cycles($urandom_range(4, 1));
        end
      end
    end

    start <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Ran %0d words (%0d encrypt, %0d decrypt) under %0d key loads,",
             encrypt_words + decrypt_words, encrypt_words, decrypt_words, key_loads);
    $display("back-to-back and with random sender gaps; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
